[hdl/rmp_pkg.sv]
// ----------------------------------------------------------------------------
// Running matrix product package
// Shared widths, defaults and the lane control bundle.
// ----------------------------------------------------------------------------
package rmp_pkg;

  // element and index widths fixed by the item format
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ROW_W  = 3;
  localparam int unsigned NCOL   = 6;

  // parameter defaults
  localparam int unsigned DIM_DEF       = 6;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // control from the sequencer to every column lane
  typedef struct packed {
    logic             mul_go;     // multiply stage loads this cycle
    logic [ROW_W-1:0] k;          // inner-product step of the multiply stage
    logic             ident;      // chain start: multiply by the identity
    logic             acc_go;     // accumulator loads this cycle
    logic             acc_first;  // first term of a sum
    logic             fin;        // finished sum leaves for the output register
    logic             commit;     // last row of a matrix: pending becomes product
    logic [ROW_W-1:0] fin_row;    // row of the finished sum
  } rmp_ctl_t;

endpackage

[hdl/rmp_in_if.sv]
// ----------------------------------------------------------------------------
// Input channel
// One matrix row per transfer, with its row index and chain-start flag.
// ----------------------------------------------------------------------------
interface rmp_in_if import rmp_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] in_col_0;
  logic signed [DATA_W-1:0] in_col_1;
  logic signed [DATA_W-1:0] in_col_2;
  logic signed [DATA_W-1:0] in_col_3;
  logic signed [DATA_W-1:0] in_col_4;
  logic signed [DATA_W-1:0] in_col_5;
  logic [ROW_W-1:0]         row_index;
  logic                     start_chain;

  modport source (
    output valid, in_col_0, in_col_1, in_col_2, in_col_3, in_col_4, in_col_5,
    output row_index, start_chain,
    input  ready
  );

  modport sink (
    input  valid, in_col_0, in_col_1, in_col_2, in_col_3, in_col_4, in_col_5,
    input  row_index, start_chain,
    output ready
  );

endinterface

[hdl/rmp_out_if.sv]
// ----------------------------------------------------------------------------
// Output channel
// One product row per transfer, with its row index and a saturation flag.
// ----------------------------------------------------------------------------
interface rmp_out_if import rmp_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_col_0;
  logic signed [DATA_W-1:0] out_col_1;
  logic signed [DATA_W-1:0] out_col_2;
  logic signed [DATA_W-1:0] out_col_3;
  logic signed [DATA_W-1:0] out_col_4;
  logic signed [DATA_W-1:0] out_col_5;
  logic [ROW_W-1:0]         out_row;
  logic                     saturated;

  modport source (
    output valid, out_col_0, out_col_1, out_col_2, out_col_3, out_col_4, out_col_5,
    output out_row, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_col_0, out_col_1, out_col_2, out_col_3, out_col_4, out_col_5,
    input  out_row, saturated,
    output ready
  );

endinterface

[hdl/rmp_lane.sv]
// ----------------------------------------------------------------------------
// Column lane
// Holds one column of the product and of the pending rows, runs one
// multiply-accumulate per step, rounds and saturates the finished sum.
// ----------------------------------------------------------------------------
module rmp_lane import rmp_pkg::*; #(
  parameter int unsigned DIM       = DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned COL       = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rmp_ctl_t                 ctl_i,
  input  logic signed [DATA_W-1:0] a_i,
  output logic signed [DATA_W-1:0] res_o,
  output logic                     sat_o
);

  localparam int unsigned KW    = $clog2(DIM);
  localparam int unsigned MUL_W = 2 * DATA_W;
  localparam int unsigned ACC_W = MUL_W + $clog2(DIM) + 1;

  localparam logic signed [DATA_W-1:0] ONE    = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W:0]    HALF   = {{ACC_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [ACC_W:0]    SAT_HI = {{(ACC_W + 2 - DATA_W){1'b0}},
                                                 {(DATA_W - 1){1'b1}}};
  localparam logic signed [ACC_W:0]    SAT_LO = {{(ACC_W + 2 - DATA_W){1'b1}},
                                                 {(DATA_W - 1){1'b0}}};

  logic signed [DATA_W-1:0] prod_q [DIM];
  logic signed [DATA_W-1:0] pend_q [DIM];
  logic signed [DATA_W-1:0] b_op;
  logic signed [MUL_W-1:0]  mul_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W:0]    rnd;
  logic signed [ACC_W:0]    shf;

  // pick the second operand: product column, or identity on a chain start
  always_comb begin
    if (ctl_i.ident) begin
      b_op = (ctl_i.k == ROW_W'(COL)) ? ONE : '0;
    end else begin
      b_op = prod_q[ctl_i.k[KW-1:0]];
    end
  end

  // add the registered product to the running sum
  always_comb begin
    acc_d = (ctl_i.acc_first ? '0 : acc_q)
          + {{(ACC_W - MUL_W){mul_q[MUL_W-1]}}, mul_q};
  end

  // multiply, then accumulate
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_go) begin
      mul_q <= a_i * b_op;
    end
    if (ctl_i.acc_go) begin
      acc_q <= acc_d;
    end
  end

  // round half up, drop fraction bits, clip to the element range
  always_comb begin
    rnd = {acc_q[ACC_W-1], acc_q} + HALF;
    shf = rnd >>> FRAC_BITS;
    if (shf > SAT_HI) begin
      res_o = SAT_HI[DATA_W-1:0];
      sat_o = 1'b1;
    end else if (shf < SAT_LO) begin
      res_o = SAT_LO[DATA_W-1:0];
      sat_o = 1'b1;
    end else begin
      res_o = shf[DATA_W-1:0];
      sat_o = 1'b0;
    end
  end

  // store the finished row element in the pending column
  always_ff @(posedge clk_i) begin
    if (ctl_i.fin) begin
      pend_q[ctl_i.fin_row[KW-1:0]] <= res_o;
    end
  end

  // product column: identity after reset, pending rows on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIM; i++) begin
        prod_q[i] <= (i == COL) ? ONE : '0;
      end
    end else if (ctl_i.commit) begin
      for (int i = 0; i < DIM; i++) begin
        prod_q[i] <= (ROW_W'(i) == ctl_i.fin_row) ? res_o : pend_q[i];
      end
    end
  end

endmodule

[hdl/rmp_seq.sv]
// ----------------------------------------------------------------------------
// Lane sequencer
// Takes input rows, steps the lanes through the inner product and tracks
// each row through the multiply, accumulate and finish stages.
// ----------------------------------------------------------------------------
module rmp_seq import rmp_pkg::*; #(
  parameter int unsigned DIM = DIM_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic signed [DATA_W-1:0] in_row_i [DIM],
  input  logic [ROW_W-1:0]         in_rowidx_i,
  input  logic                     in_start_i,
  input  logic                     out_hold_i,
  output logic                     in_ready_o,
  output logic signed [DATA_W-1:0] a_o,
  output rmp_ctl_t                 ctl_o
);

  localparam int unsigned      KW   = $clog2(DIM);
  localparam logic [ROW_W-1:0] LAST = ROW_W'(DIM - 1);

  logic busy_q, busy_d;
  logic [ROW_W-1:0] k_q, k_d;
  logic [ROW_W-1:0] row_q;
  logic start_q;
  logic signed [DATA_W-1:0] in_q [DIM];

  logic m_valid_q, m_first_q, m_last_q;
  logic [ROW_W-1:0] m_row_q;
  logic done_q;
  logic [ROW_W-1:0] d_row_q;

  logic en, hazard, take, load, row_ok;

  // freeze everything while a finished sum waits for the output register
  assign en = !(done_q && out_hold_i);

  // a new row waits until the last row of a matrix has committed
  assign hazard = (busy_q && row_q == LAST) || (m_valid_q && m_row_q == LAST)
               || (done_q && d_row_q == LAST);

  assign in_ready_o = en && (!busy_q || k_q == LAST) && !hazard;
  assign take       = in_valid_i && in_ready_o;
  assign row_ok     = {1'b0, in_rowidx_i} < (ROW_W + 1)'(DIM);
  assign load       = take && row_ok;

  // step counter
  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (busy_q) begin
      if (k_q == LAST) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q + ROW_W'(1);
      end
    end
    if (load) begin
      busy_d = 1'b1;
      k_d    = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
      done_q    <= 1'b0;
    end else if (en) begin
      busy_q    <= busy_d;
      k_q       <= k_d;
      m_valid_q <= busy_q;
      done_q    <= m_valid_q && m_last_q;
    end
  end

  // row tags and held input row
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_first_q <= (k_q == '0);
      m_last_q  <= (k_q == LAST);
      m_row_q   <= row_q;
      d_row_q   <= m_row_q;
    end
    if (load) begin
      row_q   <= in_rowidx_i;
      start_q <= in_start_i;
      for (int j = 0; j < DIM; j++) begin
        in_q[j] <= in_row_i[j];
      end
    end
  end

  assign a_o = in_q[k_q[KW-1:0]];

  // lane control bundle
  always_comb begin
    ctl_o.mul_go    = en && busy_q;
    ctl_o.k         = k_q;
    ctl_o.ident     = start_q;
    ctl_o.acc_go    = en && m_valid_q;
    ctl_o.acc_first = m_first_q;
    ctl_o.fin       = en && done_q;
    ctl_o.commit    = en && done_q && (d_row_q == LAST);
    ctl_o.fin_row   = d_row_q;
  end

endmodule

[hdl/running_6x6_matrix_product_top.sv]
// ----------------------------------------------------------------------------
// Running 6x6 matrix product
// Cumulative product P = M * P over a chain of matrices, one row per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one row of a DIM x DIM matrix in signed Q16.16.
// DIM column lanes each hold one column of the product and run one 32x32
// multiply-accumulate per cycle while the sequencer is not frozen, and rows
// are taken back to back, the next row while the last step of the one before
// runs. The product row is rounded half up and clipped to 32 bits, with
// saturated set if any element was clipped. A row that starts a chain is
// passed through unchanged. After the last row of a matrix the next input
// waits while the pending rows commit into the product. Rows with an index of
// DIM or more are taken and dropped. The output register lets the lanes keep
// working while a result waits; a finished row waits in the accumulators when
// it is full.
// ----------------------------------------------------------------------------
module running_6x6_matrix_product_top import rmp_pkg::*; #(
  parameter int unsigned DIM       = DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rmp_in_if.sink   in_i,
  rmp_out_if.source out_o
);

  logic signed [DATA_W-1:0] in_cols  [NCOL];
  logic signed [DATA_W-1:0] in_row   [DIM];
  logic signed [DATA_W-1:0] lane_res [DIM];
  logic [DIM-1:0]           lane_sat;
  logic signed [DATA_W-1:0] a_elem;
  rmp_ctl_t                 ctl;
  logic                     out_hold;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_col_q [NCOL];
  logic [ROW_W-1:0]         out_row_q;
  logic                     out_sat_q;

  assign in_cols[0] = in_i.in_col_0;
  assign in_cols[1] = in_i.in_col_1;
  assign in_cols[2] = in_i.in_col_2;
  assign in_cols[3] = in_i.in_col_3;
  assign in_cols[4] = in_i.in_col_4;
  assign in_cols[5] = in_i.in_col_5;

  // columns beyond the port read as zero
  for (genvar j = 0; j < DIM; j++) begin : g_in
    if (j < NCOL) begin : g_port
      assign in_row[j] = in_cols[j];
    end else begin : g_zero
      assign in_row[j] = '0;
    end
  end

  assign out_hold = out_valid_q && !out_o.ready;

  rmp_seq #(
    .DIM (DIM)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_row_i    (in_row),
    .in_rowidx_i (in_i.row_index),
    .in_start_i  (in_i.start_chain),
    .out_hold_i  (out_hold),
    .in_ready_o  (in_i.ready),
    .a_o         (a_elem),
    .ctl_o       (ctl)
  );

  for (genvar j = 0; j < DIM; j++) begin : g_lane
    rmp_lane #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS),
      .COL       (j)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .a_i    (a_elem),
      .res_o  (lane_res[j]),
      .sat_o  (lane_sat[j])
    );
  end

  // output valid: set on a finished row, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // merge lane results into the output register
  always_ff @(posedge clk_i) begin
    if (ctl.fin) begin
      for (int j = 0; j < NCOL; j++) begin
        out_col_q[j] <= (j < DIM) ? lane_res[j] : '0;
      end
      out_row_q <= ctl.fin_row;
      out_sat_q <= |lane_sat;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_col_0 = out_col_q[0];
  assign out_o.out_col_1 = out_col_q[1];
  assign out_o.out_col_2 = out_col_q[2];
  assign out_o.out_col_3 = out_col_q[3];
  assign out_o.out_col_4 = out_col_q[4];
  assign out_o.out_col_5 = out_col_q[5];
  assign out_o.out_row   = out_row_q;
  assign out_o.saturated = out_sat_q;

endmodule
